/* src/iti_pkg.sv */
package iti_pkg;

    localparam int MAX_EVENTS_DEF    = 2048;
    localparam int MAX_RECORDS_DEF   = 1024;
    localparam int MAX_SNAPSHOTS_DEF = 64;

    // Stored event times are as wide as the endpoint field.
    localparam int TIME_BITS      = 32;
    localparam int ID_W           = 10;
    localparam int CHK_W          = 10;
    localparam int STATUS_W       = 2;
    localparam int CFG_W          = 32;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 32'd1024;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EV_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SNAP_FULL = 2'd2;

    typedef struct packed {
        logic                 func;
        logic [ID_W-1:0]      record_id;
        logic [TIME_BITS-1:0] endpoint;
        logic                 is_start;
        logic [TIME_BITS-1:0] query_start;
        logic [TIME_BITS-1:0] query_end;
    } item_t;

    typedef struct packed {
        logic [CHK_W-1:0]    checksum;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] tstamp;
        logic [ID_W-1:0]      id;
        logic                 is_start;
    } ev_entry_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_CHK,
        S_SNAP_COPY,
        S_INS_WRITE,
        S_LB_RD,
        S_LB_CMP,
        S_UB_RD,
        S_UB_CMP,
        S_SEL_RD,
        S_SEL_CHK,
        S_RST_RD,
        S_RST_WR,
        S_REPLAY_RD,
        S_REPLAY_APPLY,
        S_SUM,
        S_RANGE_RD,
        S_RANGE_ACC,
        S_DONE
    } state_t;

    // XOR of the positions of all set bits of one bitmap word.
    function automatic logic [5:0] bit_pos_xor(input logic [63:0] w);
        logic [5:0] acc;
        acc = '0;
        for (int b = 0; b < 64; b++) begin
            if (w[b]) begin
                acc = acc ^ 6'(b);
            end
        end
        return acc;
    endfunction

endpackage

/* src/iti_event_mem.sv */
module iti_event_mem
    import iti_pkg::*;
#(
    parameter int DEPTH  = MAX_EVENTS_DEF,
    parameter int ADDR_W = $clog2(MAX_EVENTS_DEF)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  ev_entry_t         wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output ev_entry_t         rd_data
);

    ev_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/iti_snap_mem.sv */
module iti_snap_mem
    import iti_pkg::*;
#(
    parameter int BM_DEPTH  = 1024,
    parameter int BM_ADDR_W = 10,
    parameter int CNT_DEPTH = 64,
    parameter int CNT_ADDR_W = 6,
    parameter int CNT_W     = 12
) (
    input  logic                  clk,
    input  logic                  bm_wr_en,
    input  logic [BM_ADDR_W-1:0]  bm_wr_addr,
    input  logic [63:0]           bm_wr_data,
    input  logic                  bm_rd_en,
    input  logic [BM_ADDR_W-1:0]  bm_rd_addr,
    output logic [63:0]           bm_rd_data,
    input  logic                  cnt_wr_en,
    input  logic [CNT_ADDR_W-1:0] cnt_wr_addr,
    input  logic [CNT_W-1:0]      cnt_wr_data,
    input  logic                  cnt_rd_en,
    input  logic [CNT_ADDR_W-1:0] cnt_rd_addr,
    output logic [CNT_W-1:0]      cnt_rd_data
);

    // Snapshot bitmaps, one row of words per snapshot.
    logic [63:0]      bm_mem  [BM_DEPTH];
    logic [CNT_W-1:0] cnt_mem [CNT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (bm_wr_en) begin
            bm_mem[bm_wr_addr] <= bm_wr_data;
        end
        if (bm_rd_en) begin
            bm_rd_data <= bm_mem[bm_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_wr_en) begin
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        end
        if (cnt_rd_en) begin
            cnt_rd_data <= cnt_mem[cnt_rd_addr];
        end
    end

endmodule

/* src/iti_core.sv */
module iti_core
    import iti_pkg::*;
#(
    parameter int MAX_EVENTS    = MAX_EVENTS_DEF,
    parameter int MAX_RECORDS   = MAX_RECORDS_DEF,
    parameter int MAX_SNAPSHOTS = MAX_SNAPSHOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  item_t            item,
    output logic             idle,
    output logic             done_valid,
    output result_t          done_result,
    input  logic             done_take,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int BM_WORDS   = (MAX_RECORDS + 63) / 64;
    localparam int WORD_W     = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
    localparam int EV_CNT_W   = $clog2(MAX_EVENTS + 1);
    localparam int EV_ADDR_W  = $clog2(MAX_EVENTS);
    localparam int SN_CNT_W   = $clog2(MAX_SNAPSHOTS + 1);
    localparam int SN_IDX_W   = (MAX_SNAPSHOTS > 1) ? $clog2(MAX_SNAPSHOTS) : 1;
    localparam int SB_DEPTH   = MAX_SNAPSHOTS * BM_WORDS;
    localparam int SB_ADDR_W  = (SB_DEPTH > 1) ? $clog2(SB_DEPTH) : 1;
    localparam int NT_W       = CFG_W + SN_CNT_W + 1;

    state_t                state_reg, state_next;
    item_t                 req_reg, req_next;
    logic [EV_CNT_W-1:0]   ev_cnt_reg, ev_cnt_next;
    logic [SN_CNT_W-1:0]   snap_cnt_reg, snap_cnt_next;
    logic [NT_W-1:0]       next_time_reg, next_time_next;
    logic [CFG_W-1:0]      interval_reg, interval_next;
    logic [63:0]           active_reg [BM_WORDS];
    logic [63:0]           active_next [BM_WORDS];
    logic [63:0]           scratch_reg [BM_WORDS];
    logic [63:0]           scratch_next [BM_WORDS];
    logic [EV_CNT_W-1:0]   lo_reg, lo_next;
    logic [EV_CNT_W-1:0]   hi_reg, hi_next;
    logic [EV_CNT_W-1:0]   mid_reg, mid_next;
    logic [EV_CNT_W-1:0]   lb_reg, lb_next;
    logic [EV_CNT_W-1:0]   ub_reg, ub_next;
    logic [EV_CNT_W-1:0]   i_reg, i_next;
    logic [SN_CNT_W-1:0]   k_reg, k_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [CHK_W-1:0]      sum_reg, sum_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    logic [EV_CNT_W-1:0]   mid;
    logic                  ev_full, snap_full, snap_due, word_last, search_open;
    logic [CFG_W-1:0]      cfg_interval;

    logic                  ev_wr_en, ev_rd_en;
    logic [EV_ADDR_W-1:0]  ev_rd_addr;
    ev_entry_t             ev_wr_data, ev_rd_data;
    logic                  sb_wr_en, sb_rd_en, sc_wr_en, sc_rd_en;
    logic [SB_ADDR_W-1:0]  sb_wr_addr, sb_rd_addr;
    logic [63:0]           sb_rd_data;
    logic [SN_CNT_W-1:0]   k_minus;
    logic [EV_CNT_W-1:0]   sc_rd_data;

    logic [ID_W-1:0]       apply_id;
    logic                  apply_set, apply_ok;
    logic [WORD_W-1:0]     apply_word;
    logic [5:0]            apply_bit;
    logic [31:0]           word_base;
    logic [63:0]           sum_word;
    logic [CHK_W-1:0]      word_contrib;

    iti_event_mem #(
        .DEPTH  (MAX_EVENTS),
        .ADDR_W (EV_ADDR_W)
    ) u_event_mem (
        .clk     (clk),
        .wr_en   (ev_wr_en),
        .wr_addr (ev_cnt_reg[EV_ADDR_W-1:0]),
        .wr_data (ev_wr_data),
        .rd_en   (ev_rd_en),
        .rd_addr (ev_rd_addr),
        .rd_data (ev_rd_data)
    );

    iti_snap_mem #(
        .BM_DEPTH   (SB_DEPTH),
        .BM_ADDR_W  (SB_ADDR_W),
        .CNT_DEPTH  (MAX_SNAPSHOTS),
        .CNT_ADDR_W (SN_IDX_W),
        .CNT_W      (EV_CNT_W)
    ) u_snap_mem (
        .clk         (clk),
        .bm_wr_en    (sb_wr_en),
        .bm_wr_addr  (sb_wr_addr),
        .bm_wr_data  (active_reg[word_reg]),
        .bm_rd_en    (sb_rd_en),
        .bm_rd_addr  (sb_rd_addr),
        .bm_rd_data  (sb_rd_data),
        .cnt_wr_en   (sc_wr_en),
        .cnt_wr_addr (snap_cnt_reg[SN_IDX_W-1:0]),
        .cnt_wr_data (ev_cnt_reg),
        .cnt_rd_en   (sc_rd_en),
        .cnt_rd_addr (k_minus[SN_IDX_W-1:0]),
        .cnt_rd_data (sc_rd_data)
    );

    assign mid         = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign search_open = lo_reg < hi_reg;
    assign ev_full     = ev_cnt_reg >= EV_CNT_W'(MAX_EVENTS);
    assign snap_full   = snap_cnt_reg >= SN_CNT_W'(MAX_SNAPSHOTS);
    assign snap_due    = NT_W'(req_reg.endpoint) > next_time_reg;
    assign word_last   = word_reg == WORD_W'(BM_WORDS - 1);
    assign k_minus     = k_reg - SN_CNT_W'(1);
    assign cfg_interval = (cfg_data == '0) ? CFG_W'(1) : cfg_data;

    assign ev_wr_data = '{tstamp: req_reg.endpoint, id: req_reg.record_id,
                          is_start: req_reg.is_start};

    assign sb_wr_addr = SB_ADDR_W'(32'(snap_cnt_reg) * 32'(BM_WORDS) + 32'(word_reg));
    assign sb_rd_addr = SB_ADDR_W'(32'(k_minus) * 32'(BM_WORDS) + 32'(word_reg));

    // Bitmap update source: the inserted item or the replayed event.
    assign apply_id   = (state_reg == S_INS_WRITE) ? req_reg.record_id : ev_rd_data.id;
    assign apply_set  = (state_reg == S_INS_WRITE) ? req_reg.is_start : ev_rd_data.is_start;
    assign apply_ok   = 32'(apply_id) < MAX_RECORDS;
    assign apply_word = WORD_W'(apply_id >> 6);
    assign apply_bit  = apply_id[5:0];

    // A set bit at position w*64+b adds that index to the XOR; the high part
    // survives only when the word holds an odd number of ones.
    assign sum_word     = scratch_reg[word_reg];
    assign word_base    = 32'(word_reg) << 6;
    assign word_contrib = ((^sum_word) ? word_base[CHK_W-1:0] : '0)
                          ^ CHK_W'(bit_pos_xor(sum_word));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start) begin
                    state_next = (item.func == FUNC_QUERY) ? S_LB_RD : S_INS_CHK;
                end
            S_INS_CHK:
                if (ev_full) begin
                    state_next = S_DONE;
                end else if (snap_due && !snap_full) begin
                    state_next = S_SNAP_COPY;
                end else begin
                    state_next = S_INS_WRITE;
                end
            S_SNAP_COPY:
                if (word_last) begin
                    state_next = S_INS_CHK;
                end
            S_INS_WRITE:    state_next = S_DONE;
            S_LB_RD:        state_next = search_open ? S_LB_CMP : S_UB_RD;
            S_LB_CMP:       state_next = S_LB_RD;
            S_UB_RD:        state_next = search_open ? S_UB_CMP : S_SEL_RD;
            S_UB_CMP:       state_next = S_UB_RD;
            S_SEL_RD:       state_next = (k_reg != '0) ? S_SEL_CHK : S_REPLAY_RD;
            S_SEL_CHK:      state_next = (sc_rd_data <= lb_reg) ? S_RST_RD : S_SEL_RD;
            S_RST_RD:       state_next = S_RST_WR;
            S_RST_WR:       state_next = word_last ? S_REPLAY_RD : S_RST_RD;
            S_REPLAY_RD:    state_next = (i_reg < lb_reg) ? S_REPLAY_APPLY : S_SUM;
            S_REPLAY_APPLY: state_next = S_REPLAY_RD;
            S_SUM:          state_next = word_last ? S_RANGE_RD : S_SUM;
            S_RANGE_RD:     state_next = (i_reg < ub_reg) ? S_RANGE_ACC : S_DONE;
            S_RANGE_ACC:    state_next = S_RANGE_RD;
            S_DONE:
                if (done_take) begin
                    state_next = S_IDLE;
                end
            default:        state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_next       = req_reg;
        ev_cnt_next    = ev_cnt_reg;
        snap_cnt_next  = snap_cnt_reg;
        next_time_next = next_time_reg;
        interval_next  = interval_reg;
        active_next    = active_reg;
        scratch_next   = scratch_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        lb_next        = lb_reg;
        ub_next        = ub_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        word_next      = word_reg;
        sum_next       = sum_reg;
        status_next    = status_reg;
        ev_wr_en       = 1'b0;
        ev_rd_en       = 1'b0;
        ev_rd_addr     = i_reg[EV_ADDR_W-1:0];
        sb_wr_en       = 1'b0;
        sb_rd_en       = 1'b0;
        sc_wr_en       = 1'b0;
        sc_rd_en       = 1'b0;
        idle           = state_reg == S_IDLE;
        done_valid     = state_reg == S_DONE;
        done_result    = '{checksum: sum_reg, status: status_reg};

        if (cfg_we) begin
            interval_next  = cfg_interval;
            next_time_next = NT_W'(cfg_interval);
        end

        case (state_reg)
            S_IDLE:
                if (start) begin
                    req_next    = item;
                    sum_next    = '0;
                    status_next = ST_OK;
                    lo_next     = '0;
                    hi_next     = ev_cnt_reg;
                end
            S_INS_CHK:
                if (ev_full) begin
                    status_next = ST_EV_FULL;
                end else if (snap_due) begin
                    if (snap_full) begin
                        status_next = ST_SNAP_FULL;
                    end else begin
                        word_next = '0;
                    end
                end
            S_SNAP_COPY:
            begin
                sb_wr_en  = 1'b1;
                word_next = word_reg + WORD_W'(1);
                if (word_last) begin
                    sc_wr_en       = 1'b1;
                    word_next      = '0;
                    snap_cnt_next  = snap_cnt_reg + SN_CNT_W'(1);
                    next_time_next = next_time_reg + NT_W'(interval_reg);
                end
            end
            S_INS_WRITE:
            begin
                ev_wr_en    = 1'b1;
                ev_cnt_next = ev_cnt_reg + EV_CNT_W'(1);
                for (int w = 0; w < BM_WORDS; w++) begin
                    if (apply_ok && apply_word == WORD_W'(w)) begin
                        active_next[w][apply_bit] = apply_set;
                    end
                end
            end
            S_LB_RD, S_UB_RD:
            begin
                ev_rd_en   = 1'b1;
                ev_rd_addr = mid[EV_ADDR_W-1:0];
                mid_next   = mid;
                if (!search_open) begin
                    if (state_reg == S_LB_RD) begin
                        lb_next = lo_reg;
                        lo_next = '0;
                        hi_next = ev_cnt_reg;
                    end else begin
                        ub_next = lo_reg;
                        k_next  = snap_cnt_reg;
                        i_next  = '0;
                        for (int w = 0; w < BM_WORDS; w++) begin
                            scratch_next[w] = '0;
                        end
                    end
                end
            end
            S_LB_CMP:
                if (ev_rd_data.tstamp < req_reg.query_start) begin
                    lo_next = mid_reg + EV_CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
            S_UB_CMP:
                // The event orders after the end key only when it lies later,
                // or at the same time as an end event.
                if (!(req_reg.query_end < ev_rd_data.tstamp ||
                      (req_reg.query_end == ev_rd_data.tstamp && !ev_rd_data.is_start))) begin
                    lo_next = mid_reg + EV_CNT_W'(1);
                end else begin
                    hi_next = mid_reg;
                end
            S_SEL_RD:
                sc_rd_en = 1'b1;
            S_SEL_CHK:
                if (sc_rd_data <= lb_reg) begin
                    i_next    = sc_rd_data;
                    word_next = '0;
                end else begin
                    k_next = k_minus;
                end
            S_RST_RD:
                sb_rd_en = 1'b1;
            S_RST_WR:
            begin
                scratch_next[word_reg] = sb_rd_data;
                word_next = word_last ? '0 : word_reg + WORD_W'(1);
            end
            S_REPLAY_RD:
            begin
                ev_rd_en = 1'b1;
                if (!(i_reg < lb_reg)) begin
                    word_next = '0;
                end
            end
            S_REPLAY_APPLY:
            begin
                i_next = i_reg + EV_CNT_W'(1);
                for (int w = 0; w < BM_WORDS; w++) begin
                    if (apply_ok && apply_word == WORD_W'(w)) begin
                        scratch_next[w][apply_bit] = apply_set;
                    end
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg ^ word_contrib;
                if (word_last) begin
                    word_next = '0;
                    i_next    = lb_reg;
                end else begin
                    word_next = word_reg + WORD_W'(1);
                end
            end
            S_RANGE_RD:
                ev_rd_en = 1'b1;
            S_RANGE_ACC:
            begin
                i_next = i_reg + EV_CNT_W'(1);
                if (ev_rd_data.is_start) begin
                    sum_next = sum_reg ^ ev_rd_data.id;
                end
            end
            S_DONE:
                ;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            ev_cnt_reg    <= '0;
            snap_cnt_reg  <= '0;
            interval_reg  <= INTERVAL_RESET;
            next_time_reg <= NT_W'(INTERVAL_RESET);
            for (int w = 0; w < BM_WORDS; w++) begin
                active_reg[w]  <= '0;
                scratch_reg[w] <= '0;
            end
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            lb_reg     <= '0;
            ub_reg     <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            word_reg   <= '0;
            sum_reg    <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            ev_cnt_reg    <= ev_cnt_next;
            snap_cnt_reg  <= snap_cnt_next;
            interval_reg  <= interval_next;
            next_time_reg <= next_time_next;
            active_reg    <= active_next;
            scratch_reg   <= scratch_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            lb_reg        <= lb_next;
            ub_reg        <= ub_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            word_reg      <= word_next;
            sum_reg       <= sum_next;
            status_reg    <= status_next;
        end
    end

endmodule

/* src/interval_timeline_index.sv */
// An insert checks capacity, copies the active bitmap into a new checkpoint when one is due,
// then writes the event. A query binary-searches both bounds, restores the latest checkpoint
// at or before the lower bound, if any, replays events up to it, folds the bitmap into the
// checksum and XORs in the ID of each start event in range. One word is in work at a time.
// Reset clears all control state, counters and both record bitmaps at once; the event and
// checkpoint memories need no clearing pass, since only written entries are ever read.
module interval_timeline_index
    import iti_pkg::*;
#(
    parameter int MAX_EVENTS    = MAX_EVENTS_DEF,
    parameter int MAX_RECORDS   = MAX_RECORDS_DEF,
    parameter int MAX_SNAPSHOTS = MAX_SNAPSHOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic    core_idle;
    logic    core_done;
    result_t core_result;
    logic    core_take;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;

    // The engine takes a new word whenever it is idle; a finished result sits
    // in the output register, so the engine is free again while it waits.
    assign item_stall = !core_idle;
    // The interval register only changes while the engine is idle, so an
    // insert in progress never sees its checkpoint schedule move under it.
    assign cfg_ready  = core_idle;

    // A result moves into the output register when that register is empty
    // or is being emptied in the same cycle.
    assign core_take = core_done && (!result_valid_reg || !result_stall);

    iti_core #(
        .MAX_EVENTS    (MAX_EVENTS),
        .MAX_RECORDS   (MAX_RECORDS),
        .MAX_SNAPSHOTS (MAX_SNAPSHOTS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (item_valid && core_idle),
        .item        (item),
        .idle        (core_idle),
        .done_valid  (core_done),
        .done_result (core_result),
        .done_take   (core_take),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (core_take) begin
            result_valid_next = 1'b1;
            result_next       = core_result;
        end else if (!result_stall) begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end else begin
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
